// File: hw/rtl/bdtg_pkg.sv
`timescale 1ns / 1ps

package bdtg_pkg;

  // field widths fixed by the poll and result formats
  localparam int TimeW   = 32;
  localparam int BtnW    = 8;
  localparam int CoordW  = 12;
  localparam int CfgW    = 16;
  localparam int CfgAddrW = 2;
  localparam int InDataW  = 72;
  localparam int OutDataW = 144;

  localparam int NumButtonsDefault = 8;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] RegDebounce     = 2'd0;
  localparam logic [CfgAddrW-1:0] RegHomeHoldoff  = 2'd1;
  localparam logic [CfgAddrW-1:0] RegReleaseGrace = 2'd2;
  localparam logic [CfgAddrW-1:0] RegSwipeThresh  = 2'd3;

  // configuration reset values
  localparam logic [CfgW-1:0]   DebounceReset     = 16'd5;
  localparam logic [CfgW-1:0]   HomeHoldoffReset  = 16'd300;
  localparam logic [CfgW-1:0]   ReleaseGraceReset = 16'd60;
  localparam logic [CoordW-1:0] SwipeThreshReset  = 12'd30;

  // touch event codes
  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvTap   = 2'd1;
  localparam logic [1:0] EvSwipe = 2'd2;

  // contact phase codes
  localparam logic [1:0] PhaseIdle  = 2'd0;
  localparam logic [1:0] PhaseStill = 2'd1;
  localparam logic [1:0] PhaseMoved = 2'd2;

  // poll transaction, first field in the lowest bits
  typedef struct packed {
    logic              pad;
    logic              suppress_request;
    logic [2:0]        inject_button;
    logic              inject_valid;
    logic              home_pressed;
    logic [CoordW-1:0] touch_y;
    logic [CoordW-1:0] touch_x;
    logic              touch_valid;
    logic [BtnW-1:0]   raw_buttons;
    logic [TimeW-1:0]  now_ms;
  } poll_t;

  // result transaction, first field in the lowest bits
  typedef struct packed {
    logic [2:0]        pad;
    logic [TimeW-1:0]  button_hold_ms;
    logic [TimeW-1:0]  touch_hold_ms;
    logic [CoordW-1:0] current_y;
    logic [CoordW-1:0] current_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] start_x;
    logic [1:0]        touch_phase;
    logic              home_event;
    logic [1:0]        touch_event;
    logic [BtnW-1:0]   held_buttons;
    logic [BtnW-1:0]   released_mask;
    logic [BtnW-1:0]   pressed_mask;
  } result_t;

endpackage

// File: hw/rtl/button_debounce_touch_gesture.sv
`timescale 1ns / 1ps

// button debounce, touch tap/swipe classifier and home-key edge detector
//
// poll transactions enter on s_tvalid/s_tready/s_tdata, one result transaction
// per poll leaves on m_tvalid/m_tready/m_tdata, in order
// a poll is captured in an input register, then the whole step (suppress,
// home key, touch, injected one-shot, debounce) is one short pass of compares
// and 12/32-bit subtractions into the result register and the state registers
// throughput: one poll per cycle while m_tready holds, set by the single pass
// between the input and result registers
// when the receiver stalls, the result register holds its transaction, the
// input register still takes one more poll, and s_tready then drops until
// m_tready returns; no poll is lost or repeated
// reset (rst, synchronous) clears all tracking state and loads the register
// defaults: debounce 5 ms, home holdoff 300 ms, release grace 60 ms,
// swipe threshold 30
// configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once and
// are meant for idle periods only
module button_debounce_touch_gesture #(
  parameter int NUM_BUTTONS = bdtg_pkg::NumButtonsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  // poll channel
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // now_ms, raw_buttons, touch_valid, touch_x, touch_y, home_pressed,
  // inject_valid, inject_button, suppress_request
  input  logic [bdtg_pkg::InDataW-1:0]        s_tdata,
  // result channel
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pressed_mask, released_mask, held_buttons, touch_event, home_event,
  // touch_phase, start_x, start_y, current_x, current_y, touch_hold_ms,
  // button_hold_ms
  output logic [bdtg_pkg::OutDataW-1:0]       m_tdata,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [bdtg_pkg::CfgAddrW-1:0]       cfg_addr,
  input  logic [bdtg_pkg::CfgW-1:0]           cfg_wdata
);

  // buttons that exist; raw bits above them are ignored
  localparam logic [bdtg_pkg::BtnW-1:0] BtnMask =
    bdtg_pkg::BtnW'(((1 << NUM_BUTTONS) - 1) & ((1 << bdtg_pkg::BtnW) - 1));
  localparam logic [4:0] NumButtonsW = 5'(NUM_BUTTONS);

  // configuration registers
  logic [bdtg_pkg::CfgW-1:0]   debounce_ms;
  logic [bdtg_pkg::CfgW-1:0]   home_key_holdoff_ms;
  logic [bdtg_pkg::CfgW-1:0]   release_grace_ms;
  logic [bdtg_pkg::CoordW-1:0] swipe_threshold;

  // input register
  logic            in_valid;
  bdtg_pkg::poll_t in_q;

  // result register
  logic              out_valid;
  bdtg_pkg::result_t out_q;

  // tracking state
  logic [bdtg_pkg::BtnW-1:0]   last_raw, last_raw_next;
  logic [bdtg_pkg::BtnW-1:0]   stable_buttons, stable_buttons_next;
  logic [bdtg_pkg::TimeW-1:0]  last_change_time, last_change_time_next;
  logic [bdtg_pkg::TimeW-1:0]  press_start_time, press_start_time_next;
  logic [bdtg_pkg::TimeW-1:0]  press_finish_time, press_finish_time_next;
  logic                        contact_active, contact_active_next;
  logic                        contact_moved, contact_moved_next;
  logic                        tap_suppressed, tap_suppressed_next;
  logic [bdtg_pkg::CoordW-1:0] start_x, start_x_next, start_y, start_y_next;
  logic [bdtg_pkg::CoordW-1:0] last_x, last_x_next, last_y, last_y_next;
  logic [bdtg_pkg::TimeW-1:0]  contact_seen_time, contact_seen_time_next;
  logic [bdtg_pkg::TimeW-1:0]  contact_start_time, contact_start_time_next;
  logic                        home_held, home_held_next;
  logic [bdtg_pkg::TimeW-1:0]  home_event_time, home_event_time_next;

  // step datapath
  logic                        advance;
  logic [bdtg_pkg::TimeW-1:0]  now;
  logic [bdtg_pkg::BtnW-1:0]   raw;
  logic                        supp_now;
  logic                        home_ev;
  logic [bdtg_pkg::TimeW-1:0]  home_gap, seen_gap, change_gap;
  logic [bdtg_pkg::CoordW-1:0] dx, dy;
  logic [1:0]                  touch_ev;
  logic [bdtg_pkg::BtnW-1:0]   inj_bit;
  logic                        accept_change;
  logic [bdtg_pkg::BtnW-1:0]   pressed, released;
  logic [1:0]                  phase;
  bdtg_pkg::result_t           result;

  // a held poll advances when the result register is empty or its result taken
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_q;

  always_comb begin
    now      = in_q.now_ms;
    raw      = in_q.raw_buttons & BtnMask;
    home_gap = now - home_event_time;
    seen_gap = now - contact_seen_time;
    dx = (in_q.touch_x >= start_x) ? in_q.touch_x - start_x : start_x - in_q.touch_x;
    dy = (in_q.touch_y >= start_y) ? in_q.touch_y - start_y : start_y - in_q.touch_y;

    // suppress counts only while a contact is active
    supp_now = tap_suppressed || (in_q.suppress_request && contact_active);

    // home key: rising level, outside the holdoff window
    home_ev = in_q.home_pressed && !home_held &&
              (home_gap >= {16'h0, home_key_holdoff_ms});
    home_held_next       = in_q.home_pressed;
    home_event_time_next = home_ev ? now : home_event_time;

    // touch contact tracking
    touch_ev                = bdtg_pkg::EvNone;
    contact_active_next     = contact_active;
    contact_moved_next      = contact_moved;
    tap_suppressed_next     = supp_now;
    start_x_next            = start_x;
    start_y_next            = start_y;
    last_x_next             = last_x;
    last_y_next             = last_y;
    contact_seen_time_next  = contact_seen_time;
    contact_start_time_next = contact_start_time;
    if (!in_q.touch_valid) begin
      // contact ends after a gap strictly longer than the grace time
      if (contact_active && (seen_gap > {16'h0, release_grace_ms})) begin
        if (contact_moved) begin
          touch_ev = bdtg_pkg::EvSwipe;
        end else if (!supp_now) begin
          touch_ev = bdtg_pkg::EvTap;
        end
        tap_suppressed_next = 1'b0;
        contact_active_next = 1'b0;
      end
    end else begin
      contact_seen_time_next = now;
      if (!contact_active) begin
        contact_active_next     = 1'b1;
        tap_suppressed_next     = 1'b0;
        contact_moved_next      = 1'b0;
        start_x_next            = in_q.touch_x;
        start_y_next            = in_q.touch_y;
        last_x_next             = in_q.touch_x;
        last_y_next             = in_q.touch_y;
        contact_start_time_next = now;
      end else begin
        last_x_next = in_q.touch_x;
        last_y_next = in_q.touch_y;
        if (dx >= swipe_threshold || dy >= swipe_threshold) begin
          contact_moved_next = 1'b1;
        end
      end
    end

    // injected one-shot, ignored for an index past the last button
    inj_bit = '0;
    if (in_q.inject_valid && ({2'b00, in_q.inject_button} < NumButtonsW)) begin
      inj_bit = (bdtg_pkg::BtnW'(1) << in_q.inject_button) & BtnMask;
    end

    // debounce: a fresh raw change restarts the stable window at zero
    last_raw_next         = raw;
    last_change_time_next = (raw != last_raw) ? now : last_change_time;
    change_gap            = now - last_change_time;
    accept_change = (raw == last_raw) && (change_gap > {16'h0, debounce_ms}) &&
                    (raw != stable_buttons);
    pressed                = inj_bit;
    released               = inj_bit;
    stable_buttons_next    = stable_buttons;
    press_start_time_next  = press_start_time;
    press_finish_time_next = press_finish_time;
    if (accept_change) begin
      pressed  = inj_bit | (raw & ~stable_buttons);
      released = inj_bit | (stable_buttons & ~raw);
      // the injected bit counts when starting a press from all released
      if ((pressed != '0) && (stable_buttons == '0)) begin
        press_start_time_next = now;
      end
      if ((released != '0) && (raw == '0)) begin
        press_finish_time_next = now;
      end
      stable_buttons_next = raw;
    end

    if (!contact_active_next) begin
      phase = bdtg_pkg::PhaseIdle;
    end else if (contact_moved_next) begin
      phase = bdtg_pkg::PhaseMoved;
    end else begin
      phase = bdtg_pkg::PhaseStill;
    end

    result                = '0;
    result.pressed_mask   = pressed;
    result.released_mask  = released;
    result.held_buttons   = stable_buttons_next;
    result.touch_event    = touch_ev;
    result.home_event     = home_ev;
    result.touch_phase    = phase;
    result.start_x        = start_x_next;
    result.start_y        = start_y_next;
    result.current_x      = last_x_next;
    result.current_y      = last_y_next;
    result.touch_hold_ms  = (phase == bdtg_pkg::PhaseStill) ?
                            now - contact_start_time_next : '0;
    result.button_hold_ms = (stable_buttons_next != '0) ?
                            now - press_start_time_next :
                            press_finish_time_next - press_start_time_next;
  end

  // control, configuration and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid            <= 1'b0;
      out_valid           <= 1'b0;
      debounce_ms         <= bdtg_pkg::DebounceReset;
      home_key_holdoff_ms <= bdtg_pkg::HomeHoldoffReset;
      release_grace_ms    <= bdtg_pkg::ReleaseGraceReset;
      swipe_threshold     <= bdtg_pkg::SwipeThreshReset;
      last_raw            <= '0;
      stable_buttons      <= '0;
      last_change_time    <= '0;
      press_start_time    <= '0;
      press_finish_time   <= '0;
      contact_active      <= 1'b0;
      contact_moved       <= 1'b0;
      tap_suppressed      <= 1'b0;
      start_x             <= '0;
      start_y             <= '0;
      last_x              <= '0;
      last_y              <= '0;
      contact_seen_time   <= '0;
      contact_start_time  <= '0;
      home_held           <= 1'b0;
      home_event_time     <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          bdtg_pkg::RegDebounce:     debounce_ms         <= cfg_wdata;
          bdtg_pkg::RegHomeHoldoff:  home_key_holdoff_ms <= cfg_wdata;
          bdtg_pkg::RegReleaseGrace: release_grace_ms    <= cfg_wdata;
          bdtg_pkg::RegSwipeThresh:  swipe_threshold     <= cfg_wdata[bdtg_pkg::CoordW-1:0];
          default: ;
        endcase
      end
      if (advance) begin
        last_raw           <= last_raw_next;
        stable_buttons     <= stable_buttons_next;
        last_change_time   <= last_change_time_next;
        press_start_time   <= press_start_time_next;
        press_finish_time  <= press_finish_time_next;
        contact_active     <= contact_active_next;
        contact_moved      <= contact_moved_next;
        tap_suppressed     <= tap_suppressed_next;
        start_x            <= start_x_next;
        start_y            <= start_y_next;
        last_x             <= last_x_next;
        last_y             <= last_y_next;
        contact_seen_time  <= contact_seen_time_next;
        contact_start_time <= contact_start_time_next;
        home_held          <= home_held_next;
        home_event_time    <= home_event_time_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q <= s_tdata;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  // a tap or swipe is reported only on the poll that ends the contact
  a_event_ends_contact: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.touch_event != bdtg_pkg::EvNone) |->
      (out_q.touch_phase == bdtg_pkg::PhaseIdle))
    else $error("touch event reported with a contact still active");

  // hold time is only shown for an unmoved contact
  a_touch_hold_phase: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.touch_phase != bdtg_pkg::PhaseStill) |->
      (out_q.touch_hold_ms == '0))
    else $error("touch hold time outside an unmoved contact");

  // nothing reported or held for buttons that do not exist
  a_button_mask: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (((out_q.pressed_mask | out_q.released_mask |
                    out_q.held_buttons) & ~BtnMask) == '0))
    else $error("button bit beyond the configured button count");

  // back-pressure reaches the poll side only with both registers full
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("poll channel stalled with room in the pipeline");

endmodule
